// ----- design/bpa_pkg.sv -----
// Shared constants, types and command/status bundles for the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned MAX_PAGES      = 32768;
  localparam int unsigned RESERVED_PAGES = 1024;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned NUM_WORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W         = $clog2(NUM_WORDS);
  localparam int unsigned BIT_W          = $clog2(WORD_BITS);
  localparam int unsigned PAGE_W         = 15;
  localparam int unsigned CNT_W          = 16;

  localparam logic [CNT_W-1:0] MAX_PAGES_C      = CNT_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0] RESERVED_PAGES_C = CNT_W'(RESERVED_PAGES);
  localparam logic [CNT_W-1:0] TOTAL_RESET      = 16'd32768;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WIDX_W-1:0]    widx_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_TEST  = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted request and load the word index
    logic idx_inc;    // advance the word index
    logic sweep_wr;   // write the sweep pattern at the word index
    logic sweep_init; // sweep pattern is the reserved mask, not zeros
    logic alloc_chk;  // evaluate the word just read for a free page
    logic acc_chk;    // evaluate the word just read for free or test
    logic init_done;  // set the count and result for a finished init
    logic out_load;   // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic alloc_hit;
    logic alloc_end;
    logic slot_free;
  } dp_stat_t;

endpackage

// ----- design/bpa_if.sv -----
// Request, response and configuration channel interfaces of the page allocator.
`timescale 1ns / 1ps
interface bpa_req_if;
  logic           valid;
  logic           ready;
  bpa_pkg::cmd_t  cmd;
  bpa_pkg::page_t page_number;

  modport source (output valid, output cmd, output page_number, input ready);
  modport sink (input valid, input cmd, input page_number, output ready);
endinterface

interface bpa_rsp_if;
  logic           valid;
  logic           ready;
  logic           success;
  bpa_pkg::page_t result_page;
  bpa_pkg::cnt_t  used_count;

  modport source (output valid, output success, output result_page, output used_count,
                  input ready);
  modport sink (input valid, input success, input result_page, input used_count,
                output ready);
endinterface

interface bpa_cfg_if;
  logic          valid;
  logic          ready;
  bpa_pkg::cnt_t page_limit;

  modport source (output valid, output page_limit, input ready);
  modport sink (input valid, input page_limit, output ready);
endinterface

// ----- design/bpa_dp.sv -----
// Datapath of the page allocator: bitmap memory, scan logic, counters and output register.
`timescale 1ns / 1ps
module bpa_dp (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::dp_cmd_t  cmd,
  output bpa_pkg::dp_stat_t stat,
  input  bpa_pkg::cmd_t     req_cmd,
  input  bpa_pkg::page_t    req_page,
  bpa_cfg_if.sink           cfg,
  bpa_rsp_if.source         rsp
);
  import bpa_pkg::*;

  // Bits of a word whose page numbers lie below limit.
  function automatic word_t word_mask(input cnt_t limit, input cnt_t base);
    cnt_t  rem;
    word_t m;
    rem = limit - base;
    if (limit <= base) begin
      m = '0;
    end else if (rem >= CNT_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
    end
    return m;
  endfunction

  word_t bitmap [NUM_WORDS];

  cnt_t  page_limit;
  cnt_t  used_count;
  cmd_t  cmd_q;
  page_t page_q;
  widx_t word_idx;
  widx_t chk_idx;
  word_t rd_data;
  logic  res_ok;
  page_t res_page;
  logic  out_valid;
  logic  out_success;
  page_t out_page;
  cnt_t  out_count;

  cnt_t                   total_eff;
  cnt_t                   resv;
  cnt_t                   sweep_base;
  cnt_t                   chk_base;
  logic [CNT_W:0]         chk_top;
  word_t                  cand;
  logic                   hit;
  logic [BIT_W-1:0]       hit_bit;
  word_t                  page_onehot;
  logic                   page_bit;
  logic                   free_ok;
  logic                   test_ok;
  logic                   mem_we;
  widx_t                  mem_waddr;
  word_t                  mem_wdata;

  assign total_eff  = (page_limit > MAX_PAGES_C) ? MAX_PAGES_C : page_limit;
  assign resv       = (RESERVED_PAGES_C < total_eff) ? RESERVED_PAGES_C : total_eff;
  assign sweep_base = CNT_W'({word_idx, BIT_W'(0)});
  assign chk_base   = CNT_W'({chk_idx, BIT_W'(0)});
  assign chk_top    = {1'b0, chk_base} + (CNT_W+1)'(WORD_BITS);

  // Lowest free page of the word under test that is still inside the managed range.
  assign cand = ~rd_data & word_mask(total_eff, chk_base);
  assign hit  = |cand;

  always_comb begin
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign page_onehot = word_t'(1) << page_q[BIT_W-1:0];
  assign page_bit    = rd_data[page_q[BIT_W-1:0]];
  assign free_ok     = (page_q != '0) && ({1'b0, page_q} < total_eff) && page_bit;
  assign test_ok     = ({1'b0, page_q} >= total_eff) || page_bit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_idx;
    mem_wdata = '0;
    if (cmd.sweep_wr) begin
      mem_we    = 1'b1;
      mem_wdata = cmd.sweep_init ? word_mask(resv, sweep_base) : '0;
    end else if (cmd.alloc_chk && hit) begin
      mem_we    = 1'b1;
      mem_waddr = chk_idx;
      mem_wdata = rd_data | (word_t'(1) << hit_bit);
    end else if (cmd.acc_chk && cmd_q == CMD_FREE && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = chk_idx;
      mem_wdata = rd_data & ~page_onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_waddr] <= mem_wdata;
    end
    rd_data <= bitmap[word_idx];
  end

  always_ff @(posedge clk) begin
    chk_idx <= word_idx;
    if (cmd.capture) begin
      cmd_q  <= req_cmd;
      page_q <= req_page;
    end
    if (cmd.init_done) begin
      res_ok   <= 1'b1;
      res_page <= '0;
    end else if (cmd.alloc_chk) begin
      res_ok   <= hit;
      res_page <= hit ? {chk_idx, hit_bit} : '0;
    end else if (cmd.acc_chk) begin
      res_ok   <= (cmd_q == CMD_FREE) ? free_ok : test_ok;
      res_page <= '0;
    end
    // The count travels with its response so a later request cannot change it.
    if (cmd.out_load) begin
      out_success <= res_ok;
      out_page    <= res_page;
      out_count   <= used_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx    <= '0;
      used_count  <= '0;
      page_limit  <= TOTAL_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        word_idx <= (req_cmd == CMD_FREE || req_cmd == CMD_TEST) ?
                    req_page[PAGE_W-1:BIT_W] : '0;
      end else if (cmd.idx_inc) begin
        word_idx <= word_idx + widx_t'(1);
      end
      if (cmd.init_done) begin
        used_count <= resv;
      end else if (cmd.alloc_chk && hit) begin
        used_count <= used_count + cnt_t'(1);
      end else if (cmd.acc_chk && cmd_q == CMD_FREE && free_ok && used_count != '0) begin
        used_count <= used_count - cnt_t'(1);
      end
      if (cfg.valid && cfg.ready) begin
        page_limit <= cfg.page_limit;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.success     = out_success;
  assign rsp.result_page = out_page;
  assign rsp.used_count  = out_count;

  assign stat.idx_last  = (word_idx == widx_t'(NUM_WORDS - 1));
  assign stat.alloc_hit = hit;
  assign stat.alloc_end = (chk_top >= {1'b0, total_eff});
  assign stat.slot_free = !out_valid || rsp.ready;

endmodule

// ----- design/bpa_ctrl.sv -----
// Controller of the page allocator: sequences clearing, init sweep, scan and response.
`timescale 1ns / 1ps
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  bpa_pkg::cmd_t     req_cmd,
  output logic              req_ready,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t  cmd
);
  import bpa_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR      = 8'b0000_0001,
    S_IDLE       = 8'b0000_0010,
    S_INIT       = 8'b0000_0100,
    S_ALLOC_RD   = 8'b0000_1000,
    S_ALLOC_SCAN = 8'b0001_0000,
    S_ACC_RD     = 8'b0010_0000,
    S_ACC_CHK    = 8'b0100_0000,
    S_DONE       = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        // Zero the whole bitmap after reset, one word per cycle.
        cmd.sweep_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          case (req_cmd)
            CMD_INIT:  state_next = S_INIT;
            CMD_ALLOC: state_next = S_ALLOC_RD;
            default:   state_next = S_ACC_RD;
          endcase
        end
      end
      S_INIT: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_init = 1'b1;
        cmd.idx_inc    = 1'b1;
        if (stat.idx_last) begin
          cmd.init_done = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_ALLOC_RD: begin
        cmd.idx_inc = 1'b1;
        state_next  = S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        // The next word is read while the current one is checked.
        cmd.idx_inc   = 1'b1;
        cmd.alloc_chk = 1'b1;
        if (stat.alloc_hit || stat.alloc_end) begin
          state_next = S_DONE;
        end
      end
      S_ACC_RD: begin
        state_next = S_ACC_CHK;
      end
      S_ACC_CHK: begin
        cmd.acc_chk = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/bitmap_page_allocator.sv -----
// Top level of the bitmap first-fit page allocator.
//
// Requests arrive on req (cmd, page_number) with valid/ready; each request
// yields one response on rsp (success, result_page, used_count). The total
// page count is written on cfg, which is always ready; write it only while
// the block is idle. One request is in flight at a time; req is ready only
// when the controller is idle.
// Steps from request to response valid, with the receiver ready:
//   free and test: one bitmap read and one check.
//   allocate: 32-page words are scanned until a free page or the end of
//     the managed range is found, at most 1024 words.
//   init: one bitmap word written per cycle over all words.
// A further request can be taken in the cycle after the response is loaded.
// After reset the bitmap is cleared by a pass over all words, during which
// req is not ready; the count of pages in use resets to zero and the total
// to 32768. If the receiver stalls, the response is held in the output
// register; the next result waits in the datapath, the controller in S_DONE.
`timescale 1ns / 1ps
module bitmap_page_allocator (
  input logic       clk,
  input logic       rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);
  import bpa_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  bpa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .req_cmd  (req.cmd),
    .req_page (req.page_number),
    .cfg      (cfg),
    .rsp      (rsp)
  );

endmodule
